FILE: sv/imu_window_rms_activity_classifier_assert.svh
// Assertion macros shared by the classifier RTL.
`ifndef IMU_WINDOW_RMS_ACTIVITY_CLASSIFIER_ASSERT_SVH
`define IMU_WINDOW_RMS_ACTIVITY_CLASSIFIER_ASSERT_SVH
`ifndef SYNTHESIS
`define IWR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define IWR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define IWR_ASSERT(lbl, prop, msg)
`define IWR_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

FILE: sv/iwr_pkg.sv
package iwr_pkg;

  localparam int unsigned DATA_W     = 16;
  localparam int unsigned SQ_W       = 32;
  localparam int unsigned ROOT_STEPS = 16;
  localparam int unsigned CFG_WIN_W  = 9;
  localparam int unsigned CFG_IDX_W  = 3;

  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STAT_LIMIT    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LEARN_RATE    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RUN_ENTER     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RUN_EXIT      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_WALK_LEVEL    = 3'd5;

  localparam logic [1:0] ACT_UNKNOWN    = 2'd0;
  localparam logic [1:0] ACT_STATIONARY = 2'd1;
  localparam logic [1:0] ACT_WALKING    = 2'd2;
  localparam logic [1:0] ACT_RUNNING    = 2'd3;

  localparam logic [DATA_W-1:0] ONE_G     = 16'd4096;
  localparam logic [DATA_W-1:0] GRAV_LOW  = 16'd3072;
  localparam logic [DATA_W-1:0] GRAV_HIGH = 16'd5120;

  typedef enum logic {
    UOP_SQRT,
    UOP_DIV
  } uop_e;

  typedef struct packed {
    logic start;
    uop_e op;
  } unit_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

  typedef struct packed {
    logic clear;
    logic read;
    logic commit;
  } wdw_cmd_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ACC_SQ,
    S_ACC_RT,
    S_GYR_SQ,
    S_GYR_RT,
    S_SQUARE,
    S_MDIV,
    S_MRT,
    S_GDIV,
    S_GRT,
    S_GRAV,
    S_FIN
  } iwr_state_e;

endpackage

FILE: sv/iwr_unit.sv
module iwr_unit #(
  parameter int unsigned SumW = 40,
  parameter int unsigned CntW = 9
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  iwr_pkg::unit_req_t    req_i,
  input  logic [SumW-1:0]       operand_i,
  input  logic [CntW-1:0]       divisor_i,
  output iwr_pkg::unit_stat_t   stat_o,
  output logic [SumW-1:0]       result_o
);
  import iwr_pkg::*;

  localparam int unsigned RemW  = (CntW + 1 > 20) ? CntW + 1 : 20;
  localparam int unsigned StepW = $clog2(SumW + 1);

  logic             busy_q, done_q;
  uop_e             op_q;
  logic [StepW-1:0] step_q;
  logic [SumW-1:0]  src_q, res_q, src_next;
  logic [RemW-1:0]  rem_q, shifted, trial, rem_next;
  logic [CntW-1:0]  den_q;
  logic             ge;

  // One result bit per cycle: two radicand bits per root step, one dividend bit per quotient step.
  always_comb begin
    if (op_q == UOP_SQRT) begin
      shifted  = {rem_q[RemW-3:0], src_q[SQ_W-1 -: 2]};
      trial    = {res_q[RemW-3:0], 2'b01};
      src_next = src_q << 2;
    end else begin
      shifted  = {rem_q[RemW-2:0], src_q[SumW-1]};
      trial    = RemW'(den_q);
      src_next = src_q << 1;
    end
    ge       = shifted >= trial;
    rem_next = ge ? shifted - trial : shifted;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      op_q   <= UOP_SQRT;
      step_q <= '0;
    end else begin
      done_q <= busy_q && (step_q == StepW'(1));
      if (req_i.start) begin
        busy_q <= 1'b1;
        op_q   <= req_i.op;
        step_q <= (req_i.op == UOP_SQRT) ? StepW'(ROOT_STEPS) : StepW'(SumW);
      end else if (busy_q) begin
        step_q <= step_q - StepW'(1);
        if (step_q == StepW'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      src_q <= operand_i;
      den_q <= divisor_i;
      rem_q <= '0;
      res_q <= '0;
    end else if (busy_q) begin
      src_q <= src_next;
      rem_q <= rem_next;
      res_q <= {res_q[SumW-2:0], ge};
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign result_o    = res_q;

endmodule

FILE: sv/iwr_window.sv
`include "imu_window_rms_activity_classifier_assert.svh"

module iwr_window #(
  parameter int unsigned MaxWindow = 256,
  parameter int unsigned PosW      = 8,
  parameter int unsigned CntW      = 9,
  parameter int unsigned SumW      = 40
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  iwr_pkg::wdw_cmd_t              cmd_i,
  input  logic [iwr_pkg::CFG_WIN_W-1:0]  win_cfg_i,
  input  logic [iwr_pkg::SQ_W-1:0]       msq_i,
  input  logic [iwr_pkg::SQ_W-1:0]       gsq_i,
  output logic [SumW-1:0]                msum_o,
  output logic [SumW-1:0]                gsum_o,
  output logic [CntW-1:0]                fill_o
);
  import iwr_pkg::*;

  logic [2*SQ_W-1:0] mem_q [MaxWindow];
  logic [2*SQ_W-1:0] rd_q;
  logic [PosW-1:0]   pos_q;
  logic [CntW-1:0]   fill_q, win, pos_inc;
  logic [SumW-1:0]   msum_q, gsum_q, old_m, old_g;
  logic [31:0]       wl_ext;
  logic              old_vld;

  assign wl_ext = 32'(win_cfg_i);

  always_comb begin
    if (wl_ext == 32'd0) begin
      win = CntW'(1);
    end else if (wl_ext > 32'(MaxWindow)) begin
      win = CntW'(MaxWindow);
    end else begin
      win = CntW'(wl_ext);
    end
  end

  // Slots at or past the fill count hold nothing since the last clear; read them as zero.
  assign old_vld = CntW'(pos_q) < fill_q;
  assign old_m   = old_vld ? SumW'(rd_q[SQ_W-1:0]) : '0;
  assign old_g   = old_vld ? SumW'(rd_q[2*SQ_W-1:SQ_W]) : '0;
  assign pos_inc = CntW'(pos_q) + CntW'(1);

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      mem_q[pos_q] <= {gsq_i, msq_i};
    end
    if (cmd_i.read) begin
      rd_q <= mem_q[pos_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      fill_q <= '0;
      msum_q <= '0;
      gsum_q <= '0;
    end else if (cmd_i.clear) begin
      pos_q  <= '0;
      fill_q <= '0;
      msum_q <= '0;
      gsum_q <= '0;
    end else if (cmd_i.commit) begin
      msum_q <= msum_q - old_m + SumW'(msq_i);
      gsum_q <= gsum_q - old_g + SumW'(gsq_i);
      pos_q  <= (pos_inc >= win) ? '0 : PosW'(pos_inc);
      if (fill_q < win) begin
        fill_q <= fill_q + CntW'(1);
      end
    end
  end

  assign msum_o = msum_q;
  assign gsum_o = gsum_q;
  assign fill_o = fill_q;

  `IWR_ASSERT_ALWAYS(a_fill_in_window, fill_q <= win, "fill count beyond window")
  `IWR_ASSERT(a_pos_in_window, CntW'(pos_q) < win, "write position beyond window")
  `IWR_ASSERT(a_pos_tracks_fill, (fill_q != win) |-> (CntW'(pos_q) == fill_q), "position off fill")

endmodule

FILE: sv/imu_window_rms_activity_classifier.sv
// IMU activity classifier: each input beat carries one accel/gyro sample and yields exactly one
// output beat with magnitudes, windowed RMS values, the learned gravity and the activity class.
// The block takes one sample at a time; s_axis_tready is high only while it waits for a sample.
// One shared bit-serial unit runs four 16-step square roots and two long divisions (one quotient
// bit per cycle over the 32+clog2(MaxWindow) bit window sums). A single 17x17 multiplier forms
// the squares and the gravity update. Output is registered, so the next sample may be accepted
// while a result waits; a result that is still waiting when the next one is ready holds the
// block. Writing window_length clears both windows at once; configure only idle.
`include "imu_window_rms_activity_classifier_assert.svh"

module imu_window_rms_activity_classifier #(
  parameter int unsigned MaxWindow = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // accel_x, accel_y, accel_z, rate_x, rate_y, rate_z (16 bits each, from bit 0 up)
  input  logic [95:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // total_accel, dynamic_accel, move_rms, rate_rms, gravity_estimate (16 bits each),
  // activity_class (2 bits), zero pad (6 bits), from bit 0 up
  output logic [87:0] m_axis_tdata,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_wdata_i
);
  import iwr_pkg::*;

  localparam int unsigned PosW = (MaxWindow > 1) ? $clog2(MaxWindow) : 1;
  localparam int unsigned CntW = $clog2(MaxWindow + 1);
  localparam int unsigned SumW = SQ_W + PosW;

  iwr_state_e  state_q, state_d;
  logic [1:0]  cnt_q;
  logic        started_q;
  unit_req_t   ureq;
  unit_stat_t  ustat;
  wdw_cmd_t    wcmd;
  logic [SumW-1:0] uop_a, ures, msum, gsum;
  logic [CntW-1:0] fill;

  logic [CFG_WIN_W-1:0] win_len_q;
  logic [DATA_W-1:0]    stat_lim_q, learn_rate_q, run_enter_q, run_exit_q, walk_lvl_q;

  logic signed [DATA_W-1:0] ax_q, ay_q, az_q, gx_q, gy_q, gz_q, axis;
  logic signed [16:0]       mul_a, mul_b, diff;
  logic signed [33:0]       prod_q;
  logic signed [34:0]       grav_t;
  logic [SQ_W-1:0]          acc_q, msq_q;
  logic [DATA_W-1:0]        total_q, gyro_q, dyn_q, mrms_q, rrms_q, grav_q;
  logic [DATA_W-1:0]        ref_c, dyn_c, grav_new, thr;
  logic                     known_q, stationary, learn, fin_go, in_acc;
  logic [1:0]               act_q, cls;
  logic                     m_valid_q;
  logic [87:0]              m_data_q;

  assign in_acc = s_axis_tvalid && s_axis_tready;
  assign fin_go = (state_q == S_FIN) && (!m_valid_q || m_axis_tready);

  iwr_unit #(
    .SumW (SumW),
    .CntW (CntW)
  ) u_unit (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (ureq),
    .operand_i (uop_a),
    .divisor_i (fill),
    .stat_o    (ustat),
    .result_o  (ures)
  );

  iwr_window #(
    .MaxWindow (MaxWindow),
    .PosW      (PosW),
    .CntW      (CntW),
    .SumW      (SumW)
  ) u_window (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (wcmd),
    .win_cfg_i (win_len_q),
    .msq_i     (msq_q),
    .gsq_i     (prod_q[SQ_W-1:0]),
    .msum_o    (msum),
    .gsum_o    (gsum),
    .fill_o    (fill)
  );

  // Sequencer
  always_comb begin
    state_d       = state_q;
    ureq.start    = 1'b0;
    ureq.op       = UOP_SQRT;
    uop_a         = SumW'(acc_q);
    wcmd.clear    = cfg_we_i && (cfg_index_i == REG_WINDOW_LENGTH);
    wcmd.read     = 1'b0;
    wcmd.commit   = 1'b0;
    s_axis_tready = 1'b0;
    case (state_q)
      S_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          wcmd.read = 1'b1;
          state_d   = S_ACC_SQ;
        end
      end
      S_ACC_SQ: if (cnt_q == 2'd3) state_d = S_ACC_RT;
      S_ACC_RT: begin
        ureq.start = !started_q;
        if (ustat.done) state_d = S_GYR_SQ;
      end
      S_GYR_SQ: if (cnt_q == 2'd3) state_d = S_GYR_RT;
      S_GYR_RT: begin
        ureq.start = !started_q;
        if (ustat.done) state_d = S_SQUARE;
      end
      S_SQUARE: begin
        if (cnt_q == 2'd2) begin
          wcmd.commit = 1'b1;
          state_d     = S_MDIV;
        end
      end
      S_MDIV: begin
        ureq.op    = UOP_DIV;
        uop_a      = msum;
        ureq.start = !started_q;
        if (ustat.done) state_d = S_MRT;
      end
      S_MRT: begin
        uop_a      = SumW'(ures[SQ_W-1:0]);
        ureq.start = !started_q;
        if (ustat.done) state_d = S_GDIV;
      end
      S_GDIV: begin
        ureq.op    = UOP_DIV;
        uop_a      = gsum;
        ureq.start = !started_q;
        if (ustat.done) state_d = S_GRT;
      end
      S_GRT: begin
        uop_a      = SumW'(ures[SQ_W-1:0]);
        ureq.start = !started_q;
        if (ustat.done) state_d = S_GRAV;
      end
      S_GRAV: state_d = S_FIN;
      S_FIN: if (fin_go) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      cnt_q     <= '0;
      started_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= (state_d != state_q) ? 2'd0 : cnt_q + 2'd1;
      if (ureq.start) begin
        started_q <= 1'b1;
      end else if (ustat.done) begin
        started_q <= 1'b0;
      end
    end
  end

  // Shared multiplier operands
  always_comb begin
    case (cnt_q)
      2'd0:    axis = (state_q == S_GYR_SQ) ? gx_q : ax_q;
      2'd1:    axis = (state_q == S_GYR_SQ) ? gy_q : ay_q;
      default: axis = (state_q == S_GYR_SQ) ? gz_q : az_q;
    endcase
  end

  assign ref_c = known_q ? grav_q : ONE_G;
  assign dyn_c = (total_q >= ref_c) ? total_q - ref_c : ref_c - total_q;
  assign diff  = $signed({1'b0, total_q}) - $signed({1'b0, grav_q});

  always_comb begin
    mul_a = {axis[DATA_W-1], axis};
    mul_b = {axis[DATA_W-1], axis};
    case (state_q)
      S_SQUARE: begin
        mul_a = (cnt_q == 2'd0) ? $signed({1'b0, dyn_c}) : $signed({1'b0, gyro_q});
        mul_b = mul_a;
      end
      // Hold the gravity product while the result waits for the receiver
      S_GRAV, S_FIN: begin
        mul_a = $signed({1'b0, learn_rate_q});
        mul_b = diff;
      end
      default: ;
    endcase
  end

  // Gravity update rounds half up: floor((rate * diff + 2^15) / 2^16)
  assign grav_t   = 35'(prod_q) + 35'sd32768;
  assign grav_new = grav_q + grav_t[31:16];

  assign stationary = rrms_q <= stat_lim_q;
  assign learn      = stationary && (total_q >= GRAV_LOW) && (total_q <= GRAV_HIGH);
  assign thr        = (act_q == ACT_RUNNING) ? run_exit_q : run_enter_q;

  always_comb begin
    if (stationary) begin
      cls = ACT_STATIONARY;
    end else if (mrms_q >= thr) begin
      cls = ACT_RUNNING;
    end else if (mrms_q >= walk_lvl_q) begin
      cls = ACT_WALKING;
    end else begin
      cls = ACT_UNKNOWN;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    if (in_acc) begin
      ax_q <= s_axis_tdata[15:0];
      ay_q <= s_axis_tdata[31:16];
      az_q <= s_axis_tdata[47:32];
      gx_q <= s_axis_tdata[63:48];
      gy_q <= s_axis_tdata[79:64];
      gz_q <= s_axis_tdata[95:80];
    end
    if (state_q == S_ACC_SQ || state_q == S_GYR_SQ) begin
      acc_q <= (cnt_q == 2'd0) ? '0 : acc_q + prod_q[SQ_W-1:0];
    end
    if (ustat.done) begin
      case (state_q)
        S_ACC_RT: total_q <= ures[DATA_W-1:0];
        S_GYR_RT: gyro_q  <= ures[DATA_W-1:0];
        S_MRT:    mrms_q  <= ures[DATA_W-1:0];
        S_GRT:    rrms_q  <= ures[DATA_W-1:0];
        default: ;
      endcase
    end
    if (state_q == S_SQUARE) begin
      if (cnt_q == 2'd0) dyn_q <= dyn_c;
      if (cnt_q == 2'd1) msq_q <= prod_q[SQ_W-1:0];
    end
    if (fin_go) begin
      m_data_q <= {6'b0, cls, (learn ? (known_q ? grav_new : total_q) : grav_q),
                   rrms_q, mrms_q, dyn_q, total_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grav_q    <= ONE_G;
      known_q   <= 1'b0;
      act_q     <= ACT_UNKNOWN;
      m_valid_q <= 1'b0;
    end else begin
      if (fin_go) begin
        act_q     <= cls;
        m_valid_q <= 1'b1;
        if (learn) begin
          grav_q  <= known_q ? grav_new : total_q;
          known_q <= 1'b1;
        end
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_len_q    <= 9'd64;
      stat_lim_q   <= 16'd80;
      learn_rate_q <= 16'd655;
      run_enter_q  <= 16'd2458;
      run_exit_q   <= 16'd1843;
      walk_lvl_q   <= 16'd410;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_WINDOW_LENGTH: win_len_q    <= cfg_wdata_i[CFG_WIN_W-1:0];
        REG_STAT_LIMIT:    stat_lim_q   <= cfg_wdata_i;
        REG_LEARN_RATE:    learn_rate_q <= cfg_wdata_i;
        REG_RUN_ENTER:     run_enter_q  <= cfg_wdata_i;
        REG_RUN_EXIT:      run_exit_q   <= cfg_wdata_i;
        REG_WALK_LEVEL:    walk_lvl_q   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  `IWR_ASSERT(a_busy_after_accept, in_acc |=> (state_q != S_IDLE), "accept left block idle")
  `IWR_ASSERT(a_start_when_free, ureq.start |-> !ustat.busy, "unit restarted while busy")
  `IWR_ASSERT(a_idle_unit_quiet, (state_q == S_IDLE) |-> !ustat.busy, "unit busy while idle")

endmodule
